/* hw/rtl/ptwp_pkg.sv */
// ----------------------------------------------------------------------------
// ptwp_pkg: shared types and constants for the page translation block
// Entry layout, operation and status codes, config register indexes.
// ----------------------------------------------------------------------------
package ptwp_pkg;

  localparam int unsigned NumPagesDef = 1024;
  localparam int unsigned AddrW       = 32;
  localparam int unsigned FrameW      = 24;
  localparam int unsigned PermW       = 8;
  localparam int unsigned OpW         = 3;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 5;
  localparam int unsigned ShiftW      = 5;

  localparam logic [ShiftW-1:0] ShiftMin   = 5'd8;
  localparam logic [ShiftW-1:0] ShiftMax   = 5'd16;
  localparam logic [ShiftW-1:0] ShiftReset = 5'd12;
  localparam logic [PermW-1:0]  PermsPage0 = 8'h77;

  typedef enum logic [OpW-1:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_ADD    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_FLUSH  = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_DENIED  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAGE_SHIFT = 1'b0,
    CFG_TRANS_OFF  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    SW_IDLE,
    SW_CLEAR
  } sweep_state_e;

  typedef struct packed {
    logic              valid;
    logic [FrameW-1:0] frame;
    logic [PermW-1:0]  perms;
  } entry_t;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] va;
    logic             sup;
    logic             in_range;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] phys;
    status_e          status;
  } res_t;

endpackage

/* hw/rtl/page_translation_with_permissions.sv */
// ----------------------------------------------------------------------------
// page_translation_with_permissions: page table with per-page permissions
// Translates reads and writes, and adds, removes and flushes table entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per transfer;
//   output channel (out_valid_o / out_stall_i) returns exactly one result per
//   operation, in order. Configuration (page shift, translation off) must be
//   written through cfg_we_i / cfg_index_i / cfg_wdata_i only while the block
//   is idle; the block itself does not enforce this. Throughput: one operation
//   per cycle while the output is not stalled and no sweep runs. Each operation
//   reads the table at the edge where it is taken (adds and removes write it at
//   that same edge); the read data and the request are registered in the lookup
//   stage, then the result is registered in the output register. A flush also
//   clears the table: after it the input stalls while the sweep writes one
//   entry per cycle. Reset: the same sweep runs, clearing all entries and
//   installing page 0 (frame 0, flags 0x77); no input is taken meanwhile.
//   When the receiver stalls, the output register holds its result and one
//   more operation can sit in the lookup stage before the input stalls.
// ----------------------------------------------------------------------------
module page_translation_with_permissions #(
  parameter int unsigned NumPages = ptwp_pkg::NumPagesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ptwp_pkg::OpW-1:0]        op_i,
  input  logic [ptwp_pkg::AddrW-1:0]      virt_addr_i,
  input  logic [ptwp_pkg::AddrW-1:0]      phys_addr_i,
  input  logic [ptwp_pkg::PermW-1:0]      perm_flags_i,
  input  logic                            supervisor_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ptwp_pkg::AddrW-1:0]      phys_out_o,
  output logic [ptwp_pkg::StatusW-1:0]    status_o,
  input  logic                            cfg_we_i,
  input  logic [ptwp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ptwp_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import ptwp_pkg::*;

  localparam int unsigned IdxW = $clog2(NumPages);

  // config
  logic [ShiftW-1:0] shift_q, shift_d;
  logic              trans_off_q, trans_off_d;

  // stage 0
  op_e               in_op;
  logic              accept;
  logic [AddrW-1:0]  page_full;
  logic              in_range;
  logic [IdxW-1:0]   page_idx;
  logic              tbl_we;
  logic [IdxW-1:0]   tbl_waddr;
  entry_t            tbl_wdata;
  entry_t            tbl_rdata;
  entry_t            upd_entry;

  // sweep
  logic              sw_busy;
  logic              sw_we;
  logic [IdxW-1:0]   sw_idx;
  entry_t            sw_entry;

  // lookup stage and output register
  logic              s1_valid_q, s1_valid_d;
  req_t              s1_q, s1_d;
  logic              s1_adv;
  res_t              res;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  always_comb begin
    shift_d     = shift_q;
    trans_off_d = trans_off_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PAGE_SHIFT: begin
          if (cfg_wdata_i < ShiftMin) begin
            shift_d = ShiftMin;
          end else if (cfg_wdata_i > ShiftMax) begin
            shift_d = ShiftMax;
          end else begin
            shift_d = cfg_wdata_i;
          end
        end
        CFG_TRANS_OFF: begin
          trans_off_d = cfg_wdata_i[0];
        end
        default: begin
          shift_d = shift_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= ShiftReset;
      trans_off_q <= 1'b0;
    end else begin
      shift_q     <= shift_d;
      trans_off_q <= trans_off_d;
    end
  end

  assign in_op      = op_e'(op_i);
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = sw_busy || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    page_full = virt_addr_i >> shift_q;
    in_range  = page_full < AddrW'(NumPages);
    page_idx  = page_full[IdxW-1:0];

    upd_entry.valid = (in_op == OP_ADD);
    upd_entry.frame = FrameW'(phys_addr_i >> shift_q);
    upd_entry.perms = perm_flags_i;

    if (sw_we) begin
      tbl_we    = 1'b1;
      tbl_waddr = sw_idx;
      tbl_wdata = sw_entry;
    end else begin
      tbl_we    = accept && in_range && (in_op == OP_ADD || in_op == OP_REMOVE);
      tbl_waddr = page_idx;
      tbl_wdata = upd_entry;
    end
  end

  ptwp_sweep #(
    .NumPages (NumPages),
    .IdxW     (IdxW)
  ) u_sweep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && in_op == OP_FLUSH),
    .busy_o     (sw_busy),
    .wr_en_o    (sw_we),
    .wr_idx_o   (sw_idx),
    .wr_entry_o (sw_entry)
  );

  ptwp_table #(
    .NumPages (NumPages),
    .IdxW     (IdxW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (accept),
    .raddr_i (page_idx),
    .rdata_o (tbl_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (accept) begin
      s1_valid_d     = 1'b1;
      s1_d.op        = in_op;
      s1_d.va        = virt_addr_i;
      s1_d.sup       = supervisor_i;
      s1_d.in_range  = in_range;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  ptwp_resolve u_resolve (
    .req_i       (s1_q),
    .entry_i     (tbl_rdata),
    .shift_i     (shift_q),
    .trans_off_i (trans_off_q),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign phys_out_o  = out_q.phys;
  assign status_o    = out_q.status;

  a_flush_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op == OP_FLUSH) |=> sw_busy)
    else $error("flush did not start a table sweep");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("lookup stage lost its item under stall");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |-> out_q.phys == '0)
    else $error("fault result carries an address");

  a_no_take_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_we |-> !accept)
    else $error("item taken during table sweep");

endmodule

/* hw/rtl/ptwp_table.sv */
// ----------------------------------------------------------------------------
// ptwp_table: page table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptwp_table #(
  parameter int unsigned NumPages = ptwp_pkg::NumPagesDef,
  parameter int unsigned IdxW     = $clog2(NumPages)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  ptwp_pkg::entry_t  wdata_i,
  input  logic              re_i,
  input  logic [IdxW-1:0]   raddr_i,
  output ptwp_pkg::entry_t  rdata_o
);
  import ptwp_pkg::*;

  entry_t mem [NumPages];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ptwp_sweep.sv */
// ----------------------------------------------------------------------------
// ptwp_sweep: table clearing sequencer
// Walks every entry once after reset (installing page 0) and after a flush.
// ----------------------------------------------------------------------------
module ptwp_sweep #(
  parameter int unsigned NumPages = ptwp_pkg::NumPagesDef,
  parameter int unsigned IdxW     = $clog2(NumPages)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              wr_en_o,
  output logic [IdxW-1:0]   wr_idx_o,
  output ptwp_pkg::entry_t  wr_entry_o
);
  import ptwp_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumPages - 1);

  sweep_state_e    state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            init_q, init_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SW_CLEAR;
      cnt_q   <= '0;
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      init_q  <= init_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    init_d           = init_q;
    busy_o           = 1'b0;
    wr_en_o          = 1'b0;
    wr_idx_o         = cnt_q;
    wr_entry_o.valid = init_q && (cnt_q == '0);
    wr_entry_o.frame = '0;
    wr_entry_o.perms = (init_q && (cnt_q == '0)) ? PermsPage0 : '0;
    unique case (state_q)
      SW_IDLE: begin
        if (start_i) begin
          state_d = SW_CLEAR;
          cnt_d   = '0;
          init_d  = 1'b0;
        end
      end
      SW_CLEAR: begin
        busy_o  = 1'b1;
        wr_en_o = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = SW_IDLE;
          cnt_d   = '0;
          init_d  = 1'b0;
        end
      end
      default: begin
        state_d = SW_IDLE;
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == SW_IDLE)
    else $error("flush sweep started while a sweep runs");

  a_done_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(cnt_q) == LastIdx)
    else $error("sweep ended before the last entry");

  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SW_CLEAR && !init_q) |=> !init_q)
    else $error("page 0 install during flush sweep");

endmodule

/* hw/rtl/ptwp_resolve.sv */
// ----------------------------------------------------------------------------
// ptwp_resolve: translation result
// Combines a looked-up entry with the request: address build and checks.
// ----------------------------------------------------------------------------
module ptwp_resolve (
  input  ptwp_pkg::req_t                    req_i,
  input  ptwp_pkg::entry_t                  entry_i,
  input  logic [ptwp_pkg::ShiftW-1:0]       shift_i,
  input  logic                              trans_off_i,
  output ptwp_pkg::res_t                    res_o
);
  import ptwp_pkg::*;

  logic [AddrW-1:0] off_mask;
  logic [AddrW-1:0] phys_hit;
  logic [1:0]       perm_sel;
  logic             perm_ok;

  always_comb begin
    off_mask = (AddrW'(1) << shift_i) - AddrW'(1);
    phys_hit = (AddrW'(entry_i.frame) << shift_i) | (req_i.va & off_mask);
    // user read, user write, sup read, sup write map to flags 1, 2, 4, 8
    perm_sel = {req_i.sup, req_i.op == OP_WRITE};
    perm_ok  = entry_i.perms[perm_sel];

    res_o.phys   = '0;
    res_o.status = ST_OK;
    unique case (req_i.op)
      OP_READ, OP_WRITE: begin
        if (trans_off_i) begin
          res_o.phys = req_i.va;
        end else if (!req_i.in_range || !entry_i.valid) begin
          res_o.status = ST_MISSING;
        end else if (!perm_ok) begin
          res_o.status = ST_DENIED;
        end else begin
          res_o.phys = phys_hit;
        end
      end
      default: begin
        res_o.phys   = '0;
        res_o.status = ST_OK;
      end
    endcase
  end

endmodule
